[design/gpio_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO controller package
// Shared constants, register index codes and the request and response
// structures that pass between the top level and the register file.
// ----------------------------------------------------------------------------
package gpio_pkg;

  // Width of the bus data path and of the register read and write values.
  localparam int DATA_WIDTH = 32;

  // Default number of implemented pins.
  localparam int DEFAULT_PIN_COUNT = 32;

  // Bus command codes.
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Register index codes. The last code has no register behind it.
  typedef enum logic [2:0] {
    REG_DIR     = 3'd0,
    REG_OUT     = 3'd1,
    REG_IN      = 3'd2,
    REG_EN      = 3'd3,
    REG_STATUS  = 3'd4,
    REG_TRIG    = 3'd5,
    REG_POL     = 3'd6,
    REG_INVALID = 3'd7
  } gpio_reg_t;

  // One bus access as it enters the register file.
  typedef struct packed {
    logic                  cmd;
    logic [2:0]            reg_index;
    logic [DATA_WIDTH-1:0] write_data;
  } gpio_req_t;

  // The result of one bus access.
  typedef struct packed {
    logic [DATA_WIDTH-1:0] read_data;
    logic                  irq;
    logic                  bad;
  } gpio_rsp_t;

endpackage

[design/gpio_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO register file
// Holds the direction, output, enable, status, trigger mode and polarity
// registers, performs one access per accepted transaction and computes the
// edge and level interrupt status.
// ----------------------------------------------------------------------------
module gpio_regs #(
  parameter int PIN_COUNT = gpio_pkg::DEFAULT_PIN_COUNT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  gpio_pkg::gpio_req_t req,
  output gpio_pkg::gpio_rsp_t rsp
);
  import gpio_pkg::*;

  // Architectural state, one bit per pin.
  logic [PIN_COUNT-1:0] pin_direction, pin_direction_next;
  logic [PIN_COUNT-1:0] pin_output,    pin_output_next;
  logic [PIN_COUNT-1:0] irq_enable,    irq_enable_next;
  logic [PIN_COUNT-1:0] irq_status,    irq_status_next;
  logic [PIN_COUNT-1:0] level_mode,    level_mode_next;
  logic [PIN_COUNT-1:0] active_high,   active_high_next;

  logic [PIN_COUNT-1:0] data;
  logic [PIN_COUNT-1:0] pins_before;
  logic [PIN_COUNT-1:0] pins_after;
  logic [PIN_COUNT-1:0] rise;
  logic [PIN_COUNT-1:0] fall;
  logic [PIN_COUNT-1:0] edge_cand;
  logic [PIN_COUNT-1:0] status_wr;
  logic [PIN_COUNT-1:0] level_sel;
  logic [PIN_COUNT-1:0] level_active;
  logic [PIN_COUNT-1:0] rd;
  logic                 is_write;
  logic                 write_ok;
  logic                 bad;
  gpio_reg_t            idx;

  assign data     = req.write_data[PIN_COUNT-1:0];
  assign is_write = (req.cmd == CMD_WRITE);
  assign idx      = gpio_reg_t'(req.reg_index);

  // Edge detection on the pin values seen before and after an output write.
  assign pins_before = pin_output & pin_direction;
  assign pins_after  = data & pin_direction;
  assign rise        = ~pins_before & pins_after;
  assign fall        = pins_before & ~pins_after;
  assign edge_cand   = pin_direction & irq_enable & ~level_mode;

  // Register decode: reads select a value, writes load the addressed register.
  always_comb begin
    pin_direction_next = pin_direction;
    pin_output_next    = pin_output;
    irq_enable_next    = irq_enable;
    status_wr          = irq_status;
    level_mode_next    = level_mode;
    active_high_next   = active_high;
    rd                 = '0;
    bad                = 1'b0;
    write_ok           = 1'b0;
    case (idx)
      REG_DIR: begin
        if (is_write) begin
          pin_direction_next = data;
          write_ok           = 1'b1;
        end else begin
          rd = pin_direction;
        end
      end
      REG_OUT: begin
        if (is_write) begin
          pin_output_next = data;
          status_wr       = irq_status |
                            (edge_cand & ((active_high & rise) | (~active_high & fall)));
          write_ok        = 1'b1;
        end else begin
          rd = pin_output;
        end
      end
      REG_IN: begin
        if (is_write) begin
          bad = 1'b1;
        end else begin
          rd = pins_before;
        end
      end
      REG_EN: begin
        if (is_write) begin
          irq_enable_next = data;
          write_ok        = 1'b1;
        end else begin
          rd = irq_enable;
        end
      end
      REG_STATUS: begin
        if (is_write) begin
          status_wr = irq_status & ~data;
          write_ok  = 1'b1;
        end else begin
          rd = irq_status;
        end
      end
      REG_TRIG: begin
        if (is_write) begin
          level_mode_next = data;
          write_ok        = 1'b1;
        end else begin
          rd = level_mode;
        end
      end
      REG_POL: begin
        if (is_write) begin
          active_high_next = data;
          write_ok         = 1'b1;
        end else begin
          rd = active_high;
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  // Enabled level-mode pins follow their active level after every successful write.
  assign level_sel    = irq_enable_next & level_mode_next;
  assign level_active = ~((pin_output_next & pin_direction_next) ^ active_high_next);
  assign irq_status_next = write_ok ? ((status_wr & ~level_sel) | (level_active & level_sel))
                                    : status_wr;

  // Response for the current transaction.
  assign rsp.read_data = DATA_WIDTH'(rd);
  assign rsp.irq       = |irq_status_next;
  assign rsp.bad       = bad;

  // State update on each accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      pin_direction <= '0;
      pin_output    <= '0;
      irq_enable    <= '0;
      irq_status    <= '0;
      level_mode    <= '0;
      active_high   <= '0;
    end else if (req_valid) begin
      pin_direction <= pin_direction_next;
      pin_output    <= pin_output_next;
      irq_enable    <= irq_enable_next;
      irq_status    <= irq_status_next;
      level_mode    <= level_mode_next;
      active_high   <= active_high_next;
    end
  end

  // Reads never change any register.
  a_read_no_change: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req.cmd == CMD_READ) |=>
      ($stable(irq_status) && $stable(pin_output) && $stable(pin_direction)))
    else $error("A register read changed the register state.");

  // A rejected write leaves every register unchanged.
  a_bad_write_no_change: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req.cmd == CMD_WRITE &&
     (req.reg_index == REG_IN || req.reg_index == REG_INVALID)) |=>
      ($stable(irq_status) && $stable(pin_output) && $stable(pin_direction) &&
       $stable(irq_enable) && $stable(level_mode) && $stable(active_high)))
    else $error("A rejected write changed the register state.");

  // Enabled level-mode pins always show their active level in the status.
  a_level_status: assert property (@(posedge clk) disable iff (rst)
    ((irq_status ^ ~((pin_output & pin_direction) ^ active_high)) &
     irq_enable & level_mode) == '0)
    else $error("Level-mode status does not match the pin level.");

endmodule

[design/gpio_controller_with_interrupts.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO controller with edge and level interrupts
// Bus register access to direction, output, input, interrupt enable,
// interrupt status, trigger mode and polarity registers, with one
// registered result per transaction.
// ----------------------------------------------------------------------------
// Each input transaction is one register read or write. The access is
// decoded and applied in the cycle it is accepted, and its result
// (read_data, irq_level, bad_access) appears in the output register on the
// next cycle, and a new transaction can be accepted in every cycle in which
// in_stall is low. The output register is the only buffer: in_stall
// is raised only while a result is held there and out_stall is high. The
// pin input value is the output register ANDed with the direction register.
// Status bits are write-1-to-clear, and irq_level reports whether any status
// bit is set after the access.
module gpio_controller_with_interrupts #(
  parameter int PIN_COUNT = gpio_pkg::DEFAULT_PIN_COUNT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            cmd,
  input  logic [2:0]                      reg_index,
  input  logic [gpio_pkg::DATA_WIDTH-1:0] write_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [gpio_pkg::DATA_WIDTH-1:0] read_data,
  output logic                            irq_level,
  output logic                            bad_access
);
  import gpio_pkg::*;

  logic      in_accept;
  logic      out_valid_next;
  gpio_req_t req;
  gpio_rsp_t rsp;

  // Accept a transaction whenever the output register is free or draining.
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign req.cmd        = cmd;
  assign req.reg_index  = reg_index;
  assign req.write_data = write_data;

  gpio_regs #(
    .PIN_COUNT (PIN_COUNT)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .req_valid (in_accept),
    .req       (req),
    .rsp       (rsp)
  );

  // Output valid holds while stalled and reloads on every accepted transaction.
  always_comb begin
    if (in_accept) begin
      out_valid_next = 1'b1;
    end else if (out_stall) begin
      out_valid_next = out_valid;
    end else begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      read_data  <= rsp.read_data;
      irq_level  <= rsp.irq;
      bad_access <= rsp.bad;
    end
  end

  // Every accepted transaction produces a result on the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("Accepted transaction produced no result.");

  // A pending result is never overwritten by a new transaction.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !in_accept)
    else $error("Pending result overwritten.");

  // A flagged access never returns read data.
  a_bad_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_access) |-> (read_data == '0))
    else $error("Bad access returned nonzero read data.");

endmodule

[sim/tb_gpio_controller_with_interrupts.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the GPIO controller with edge and level interrupts
// Sends register read and write transactions, predicts each response from a
// shadow copy of the register state, and checks every response field by
// field. Both sides idle and stall at random, with a long back-pressure hold.
// ----------------------------------------------------------------------------
module tb_gpio_controller_with_interrupts;
  import gpio_pkg::*;

  localparam int          PIN_COUNT  = DEFAULT_PIN_COUNT;
  localparam logic [31:0] PIN_MASK   = 32'hFFFF_FFFF >> (32 - PIN_COUNT);
  localparam int          RANDOM_TXN = 700;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic                  cmd        = CMD_READ;
  logic [2:0]            reg_index  = REG_DIR;
  logic [DATA_WIDTH-1:0] write_data = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [DATA_WIDTH-1:0] read_data;
  logic                  irq_level;
  logic                  bad_access;

  // Transactions still to be sent and responses still to be checked.
  gpio_req_t access_queue[$];
  gpio_rsp_t expected_responses[$];

  // Shadow copy of the controller registers.
  logic [31:0] shadow_dir    = '0;
  logic [31:0] shadow_out    = '0;
  logic [31:0] shadow_en     = '0;
  logic [31:0] shadow_status = '0;
  logic [31:0] shadow_level  = '0;
  logic [31:0] shadow_pol    = '0;

  int sent_count     = 0;
  int received_count = 0;
  int error_count    = 0;
  int hold_left      = 0;
  bit pressure_done  = 1'b0;

  gpio_controller_with_interrupts #(
    .PIN_COUNT(PIN_COUNT)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .reg_index (reg_index),
    .write_data(write_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_data (read_data),
    .irq_level (irq_level),
    .bad_access(bad_access)
  );

  // Clock generation.
  initial begin
    forever #6 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Applies one transaction to the shadow registers and returns its response.
  task automatic apply_bus_access(input gpio_req_t acc, output gpio_rsp_t rsp);
    logic [31:0] data;
    logic [31:0] pins_old;
    logic [31:0] pins_new;
    logic [31:0] rise;
    logic [31:0] fall;
    logic [31:0] edge_pins;
    logic [31:0] sel;
    logic [31:0] at_level;
    data = acc.write_data & PIN_MASK;
    rsp  = '0;
    if (gpio_reg_t'(acc.reg_index) == REG_INVALID) begin
      rsp.bad = 1'b1;
    end else if (acc.cmd == CMD_READ) begin
      case (gpio_reg_t'(acc.reg_index))
        REG_DIR:    rsp.read_data = shadow_dir;
        REG_OUT:    rsp.read_data = shadow_out;
        REG_IN:     rsp.read_data = shadow_out & shadow_dir;
        REG_EN:     rsp.read_data = shadow_en;
        REG_STATUS: rsp.read_data = shadow_status;
        REG_TRIG:   rsp.read_data = shadow_level;
        default:    rsp.read_data = shadow_pol;
      endcase
    end else if (gpio_reg_t'(acc.reg_index) == REG_IN) begin
      rsp.bad = 1'b1;
    end else begin
      case (gpio_reg_t'(acc.reg_index))
        REG_DIR: shadow_dir = data;
        REG_OUT: begin
          // Edge detection on enabled edge-mode output pins.
          pins_old   = shadow_out & shadow_dir;
          shadow_out = data;
          pins_new   = shadow_out & shadow_dir;
          rise       = ~pins_old & pins_new;
          fall       = pins_old & ~pins_new;
          edge_pins  = shadow_dir & shadow_en & ~shadow_level;
          shadow_status |= edge_pins & ((shadow_pol & rise) | (~shadow_pol & fall));
        end
        REG_EN:     shadow_en = data;
        REG_STATUS: shadow_status &= ~data;
        REG_TRIG:   shadow_level = data;
        default:    shadow_pol = data;
      endcase
      // Enabled level-mode pins follow their active level after every valid write.
      sel           = shadow_en & shadow_level;
      at_level      = ~((shadow_out & shadow_dir) ^ shadow_pol) & PIN_MASK;
      shadow_status = ((shadow_status & ~sel) | (at_level & sel)) & PIN_MASK;
    end
    rsp.irq = |shadow_status;
  endtask

  task automatic queue_access(input logic c, input gpio_reg_t idx, input logic [31:0] d);
    gpio_req_t acc;
    acc.cmd        = c;
    acc.reg_index  = idx;
    acc.write_data = d;
    access_queue.push_back(acc);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    error_count++;
    $display("[%0t] mismatch on response %0d, %s: expected %h, got %h",
             $time, received_count, field, want, got);
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h1 << $urandom_range(0, 31);
      3:       return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  // Sender idles at random, except over a long stretch in the middle.
  function automatic bit sender_rests();
    return (sent_count < 300 || sent_count >= 450) && ($urandom_range(0, 99) < 22);
  endfunction

  function automatic bit receiver_rests();
    return (received_count < 300 || received_count >= 450) &&
           ($urandom_range(0, 99) < 22);
  endfunction

  // Driver: predicts each accepted transaction and presents the next one.
  always @(posedge clk) begin
    gpio_req_t acc;
    gpio_rsp_t rsp;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        acc.cmd        = cmd;
        acc.reg_index  = reg_index;
        acc.write_data = write_data;
        apply_bus_access(acc, rsp);
        expected_responses.push_back(rsp);
        sent_count++;
      end
      if (!in_valid || !in_stall) begin
        if (access_queue.size() > 0 && !sender_rests()) begin
          acc = access_queue.pop_front();
          in_valid   <= 1'b1;
          cmd        <= acc.cmd;
          reg_index  <= acc.reg_index;
          write_data <= acc.write_data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted response and drives the stall.
  always @(posedge clk) begin
    gpio_rsp_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_responses.size() == 0) begin
          error_count++;
          $display("[%0t] response with no transaction outstanding", $time);
        end else begin
          want = expected_responses.pop_front();
          if (read_data !== want.read_data)
            report_mismatch("read_data", want.read_data, read_data);
          if (irq_level !== want.irq)
            report_mismatch("irq_level", {31'b0, want.irq}, {31'b0, irq_level});
          if (bad_access !== want.bad)
            report_mismatch("bad_access", {31'b0, want.bad}, {31'b0, bad_access});
        end
        received_count++;
      end
      // One long hold lets the output register fill and stall the input.
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!pressure_done && received_count >= 150) begin
        pressure_done = 1'b1;
        hold_left     = 60;
        out_stall    <= 1'b1;
      end else begin
        out_stall <= receiver_rests();
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    logic      c;
    gpio_reg_t idx;
    int        r;

    // Reset values, then every register mode and corner.
    queue_access(CMD_READ,  REG_DIR,     32'h0);
    queue_access(CMD_WRITE, REG_DIR,     32'hFFFF_FFFF);
    queue_access(CMD_WRITE, REG_TRIG,    32'h0000_FFFF);
    queue_access(CMD_WRITE, REG_POL,     32'h00FF_00FF);
    queue_access(CMD_WRITE, REG_EN,      32'hFFFF_FFFF);
    queue_access(CMD_WRITE, REG_OUT,     32'hFFFF_FFFF);
    queue_access(CMD_READ,  REG_IN,      32'h0);
    queue_access(CMD_READ,  REG_STATUS,  32'h0);
    queue_access(CMD_WRITE, REG_STATUS,  32'hFFFF_FFFF);
    queue_access(CMD_READ,  REG_STATUS,  32'h0);
    queue_access(CMD_WRITE, REG_OUT,     32'h0000_0000);
    queue_access(CMD_READ,  REG_STATUS,  32'h0);
    // Bad accesses: write to the input register, read and write the unused index; then read back the others.
    queue_access(CMD_WRITE, REG_IN,      32'h1234_5678);
    queue_access(CMD_READ,  REG_INVALID, 32'h0);
    queue_access(CMD_WRITE, REG_INVALID, 32'hFFFF_FFFF);
    queue_access(CMD_READ,  REG_OUT,     32'h0);
    queue_access(CMD_READ,  REG_EN,      32'h0);
    queue_access(CMD_READ,  REG_TRIG,    32'h0);
    queue_access(CMD_READ,  REG_POL,     32'h0);
    // Edges on input pins and on disabled pins must not set status.
    queue_access(CMD_WRITE, REG_STATUS,  32'hFFFF_FFFF);
    queue_access(CMD_WRITE, REG_DIR,     32'h0000_0000);
    queue_access(CMD_WRITE, REG_OUT,     32'hFFFF_FFFF);
    queue_access(CMD_WRITE, REG_EN,      32'h0000_0000);
    queue_access(CMD_WRITE, REG_DIR,     32'hFFFF_FFFF);
    queue_access(CMD_READ,  REG_STATUS,  32'h0);

    // Random transactions, weighted toward output register accesses that make edges.
    for (int i = 0; i < RANDOM_TXN; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0)
        idx = REG_INVALID;
      else if (r < 7)
        idx = REG_OUT;
      else
        idx = gpio_reg_t'($urandom_range(0, 6));
      c = ($urandom_range(0, 9) < 6) ? CMD_WRITE : CMD_READ;
      queue_access(c, idx, random_word());
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    wait (access_queue.size() == 0 && !in_valid && expected_responses.size() == 0);
    repeat (10) @(posedge clk);

    if (expected_responses.size() != 0) begin
      error_count++;
      $display("%0d responses never arrived", expected_responses.size());
    end
    if (error_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
